// ===== rtl/ctok_pkg.sv =====
package ctok_pkg;

	localparam int KwCount        = 13;
	localparam int KwSlots        = 8;
	localparam int MaxTokenLength = 63;
	localparam int QueueDepth     = 4;

	typedef enum logic [3:0] {
		KIND_EOF      = 4'd0,
		KIND_IDENT    = 4'd1,
		KIND_NUMBER   = 4'd2,
		KIND_OPERATOR = 4'd3,
		KIND_PAREN    = 4'd4,
		KIND_BRACE    = 4'd5,
		KIND_SEMI     = 4'd6,
		KIND_KEYWORD  = 4'd7,
		KIND_UNKNOWN  = 4'd8
	} tok_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_IDENT  = 2'd2
	} scan_mode_t;

	typedef struct packed {
		scan_mode_t          mode;
		logic [5:0]          len;
		logic [7:0]          first;
		logic [KwCount-1:0]  cand;
	} scan_state_t;

	typedef struct packed {
		logic       last;
		logic [3:0] kwi;
		logic [7:0] first;
		logic [5:0] len;
		tok_kind_t  kind;
	} token_t;

	localparam logic [7:0] KwText [KwCount][KwSlots] = '{
		'{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"r", "e", "t", "u", "r", "n", 8'h0, 8'h0},
		'{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0},
		'{"v", "o", "i", "d", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"c", "h", "a", "r", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"d", "o", "u", "b", "l", "e", 8'h0, 8'h0},
		'{"f", "l", "o", "a", "t", 8'h0, 8'h0, 8'h0},
		'{"b", "r", "e", "a", "k", 8'h0, 8'h0, 8'h0},
		'{"c", "o", "n", "t", "i", "n", "u", "e"},
		'{"s", "t", "r", "u", "c", "t", 8'h0, 8'h0}
	};

	localparam logic [3:0] KwLen [KwCount] = '{
		4'd3, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd4, 4'd4, 4'd6, 4'd5, 4'd5, 4'd8, 4'd6
	};

	// keep keywords whose character at pos equals c
	function automatic logic [KwCount-1:0] kw_narrow(
		input logic [KwCount-1:0] mask,
		input logic [5:0]         pos,
		input logic [7:0]         c
	);
		logic [KwCount-1:0] keep;
		keep = '0;
		for (int k = 0; k < KwCount; k++) begin
			if (mask[k] && (pos < {2'b00, KwLen[k]}) && (KwText[k][pos[2:0]] == c))
				keep[k] = 1'b1;
		end
		return keep;
	endfunction

endpackage

// ===== rtl/ctok_scan.sv =====
module ctok_scan
	import ctok_pkg::*;
(
	input  scan_state_t cur,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output scan_state_t nxt,
	output token_t      res0,
	output token_t      res1,
	output logic [1:0]  res_cnt
);

	logic        is_digit, is_alpha, is_space, is_word, is_open, extend;
	logic        flush_v, single_v;
	token_t      flush_tok, single_tok, eof_tok;
	scan_mode_t  mode;
	scan_state_t idle_st, start_st;

	assign is_digit = (char_code >= "0") && (char_code <= "9");
	assign is_alpha = ((char_code >= "a") && (char_code <= "z")) ||
	                  ((char_code >= "A") && (char_code <= "Z"));
	assign is_space = (char_code == " ") || ((char_code >= 8'd9) && (char_code <= 8'd13));
	assign is_word  = is_alpha || is_digit || (char_code == "_");

	always_comb begin
		unique case (cur.mode)
			MODE_NUMBER: mode = MODE_NUMBER;
			MODE_IDENT:  mode = MODE_IDENT;
			default:     mode = MODE_IDLE;
		endcase
	end

	assign is_open = (mode != MODE_IDLE);
	assign idle_st = '{mode: MODE_IDLE, len: '0, first: '0, cand: '0};

	always_comb begin
		unique case (mode)
			MODE_NUMBER: extend = is_digit;
			MODE_IDENT:  extend = is_word;
			default:     extend = 1'b0;
		endcase
	end

	// token for the open run, keyword lookup takes the lowest matching index
	always_comb begin
		flush_tok       = '0;
		flush_tok.kind  = (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
		flush_tok.len   = cur.len;
		flush_tok.first = cur.first;
		if (mode == MODE_IDENT) begin
			for (int k = KwCount - 1; k >= 0; k--) begin
				if (cur.cand[k] && ({2'b00, KwLen[k]} == cur.len)) begin
					flush_tok.kind = KIND_KEYWORD;
					flush_tok.kwi  = 4'(k);
				end
			end
		end
	end

	// a byte seen with no run open
	always_comb begin
		single_tok       = '0;
		single_tok.len   = 6'd1;
		single_tok.first = char_code;
		single_v         = 1'b0;
		start_st         = idle_st;
		priority if (is_space) begin
			single_v = 1'b0;
		end else if (is_digit) begin
			start_st = '{mode: MODE_NUMBER, len: 6'd1, first: char_code, cand: '0};
		end else if (is_alpha || (char_code == "_")) begin
			start_st = '{mode: MODE_IDENT, len: 6'd1, first: char_code,
			             cand: kw_narrow('1, 6'd0, char_code)};
		end else begin
			single_v = 1'b1;
			priority if (char_code == "+" || char_code == "-" || char_code == "*" ||
			             char_code == "/" || char_code == "=" || char_code == "<" ||
			             char_code == ">")
				single_tok.kind = KIND_OPERATOR;
			else if (char_code == "(" || char_code == ")")
				single_tok.kind = KIND_PAREN;
			else if (char_code == "{" || char_code == "}")
				single_tok.kind = KIND_BRACE;
			else if (char_code == ";")
				single_tok.kind = KIND_SEMI;
			else
				single_tok.kind = KIND_UNKNOWN;
		end
	end

	always_comb begin
		eof_tok      = '0;
		eof_tok.kind = KIND_EOF;
	end

	always_comb begin
		nxt     = cur;
		nxt.mode = mode;
		res0    = '0;
		res1    = '0;
		res_cnt = 2'd0;
		flush_v = 1'b0;
		if (end_of_input) begin
			nxt = idle_st;
			if (is_open) begin
				res0    = flush_tok;
				res1    = eof_tok;
				res_cnt = 2'd2;
			end else begin
				res0    = eof_tok;
				res_cnt = 2'd1;
			end
		end else if (is_open && extend && (cur.len < 6'(MaxTokenLength))) begin
			nxt.len = cur.len + 6'd1;
			if (mode == MODE_IDENT)
				nxt.cand = kw_narrow(cur.cand, cur.len, char_code);
		end else begin
			nxt     = start_st;
			flush_v = is_open;
			if (flush_v) begin
				res0 = flush_tok;
				if (single_v) begin
					res1    = single_tok;
					res_cnt = 2'd2;
				end else begin
					res_cnt = 2'd1;
				end
			end else if (single_v) begin
				res0    = single_tok;
				res_cnt = 2'd1;
			end
		end
		if (res_cnt == 2'd1)
			res0.last = 1'b1;
		if (res_cnt == 2'd2)
			res1.last = 1'b1;
	end

endmodule

// ===== rtl/c_token_lexer.sv =====
// C lexical tokenizer.
// Slave side: one item per source byte in s_axis_tdata, or an end-of-input
// mark when s_axis_tuser is set (tdata then ignored). Each item gives zero,
// one or two tokens on the master side; tlast flags the final token of an item.
// Master tuser: token kind. Master tdata: length, first byte, keyword index.
// Tokens are registered in the output queue before they appear on m_axis.
// Throughput: one item per cycle while the receiver keeps up and the queue has
// room; an item ending a run and giving its own token produces two tokens,
// which leave one at a time through the four-entry output queue.
// s_axis_tready is high while the queue has room for two tokens, so a stalled
// receiver fills the queue and then holds off the source; nothing is dropped.
// Reset clears the scanner to idle with no run open and empties the queue.
// End of input flushes any open run, then gives an eof token.
module c_token_lexer
	import ctok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic [0:0]  s_axis_tuser,  // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [5:0] token_length, [13:6] first_char,
	                                   // [17:14] keyword_index
	output logic [3:0]  m_axis_tuser,  // [3:0] token_kind
	output logic        m_axis_tlast
);

	localparam int PtrBits = $clog2(QueueDepth);

	scan_state_t        state_q, state_nxt;
	token_t             res0, res1;
	logic [1:0]         res_cnt;
	token_t             queue_q [QueueDepth];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrBits:0]   count_q;
	logic               accept, pop;
	logic [1:0]         push;

	ctok_scan u_scan (
		.cur          (state_q),
		.char_code    (s_axis_tdata),
		.end_of_input (s_axis_tuser[0]),
		.nxt          (state_nxt),
		.res0         (res0),
		.res1         (res1),
		.res_cnt      (res_cnt)
	);

	assign s_axis_tready = (count_q <= (PtrBits+1)'(QueueDepth - 2));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept ? res_cnt : 2'd0;
	assign m_axis_tvalid = (count_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;

	token_t head;
	assign head         = queue_q[rd_ptr_q];
	assign m_axis_tdata = {6'b0, head.kwi, head.first, head.len};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '{mode: MODE_IDLE, len: '0, first: '0, cand: '0};
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept)
				state_q <= state_nxt;
			wr_ptr_q <= wr_ptr_q + PtrBits'(push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PtrBits'(1);
			count_q <= count_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push != 2'd0)
			queue_q[wr_ptr_q] <= res0;
		if (push == 2'd2)
			queue_q[wr_ptr_q + PtrBits'(1)] <= res1;
	end

endmodule
